>>> hdl/wrsi_pkg.sv
// ----------------------------------------------------------------------------
// wrsi_pkg
// Shared widths and constants for the Wilder RSI stream unit.
// ----------------------------------------------------------------------------
package wrsi_pkg;

	localparam int PRICE_W = 32;                     // Q16.16 price
	localparam int WIN_W   = 8;                      // window register
	localparam int SEEN_W  = 9;                      // change counter, holds window + 1
	localparam int MEAN_W  = 48;                     // Q32.16 averages and sums
	localparam int MAC_W   = MEAN_W + WIN_W + 1;     // mean * (W-1) + change
	localparam int PCT_W   = 7;                      // bits of the percent scale

	localparam logic [PCT_W-1:0] PCT_SCALE  = 7'd100;
	localparam logic [WIN_W-1:0] WIN_RESET  = 8'd14;

endpackage

>>> hdl/wrsi_if.sv
// ----------------------------------------------------------------------------
// wrsi_if
// Valid/ready channels of the RSI unit: price items in, RSI items out.
// ----------------------------------------------------------------------------
interface wrsi_price_if import wrsi_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [PRICE_W-1:0] price;
	logic               start_series;

	modport source (output valid, price, start_series, input ready);
	modport sink   (input valid, price, start_series, output ready);
endinterface

interface wrsi_rsi_if #(parameter int RSI_W = 23) ();
	logic             valid;
	logic             ready;
	logic [RSI_W-1:0] rsi;

	modport source (output valid, rsi, input ready);
	modport sink   (input valid, rsi, output ready);
endinterface

>>> hdl/wrsi_sdiv.sv
// ----------------------------------------------------------------------------
// wrsi_sdiv
// Bit-serial restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wrsi_sdiv import wrsi_pkg::*; #(
	parameter int NUM_W = 57,
	parameter int DEN_W = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output logic             done,
	output logic [NUM_W-1:0] quotient
);

	localparam int CNT_W = $clog2(NUM_W + 1);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(NUM_W - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] quo_q;   // dividend shifts out at the top, quotient in at the bottom
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;

	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             fits;
	logic [DEN_W-1:0] rem_next;

	assign trial    = {rem_q, quo_q[NUM_W-1]};
	assign diff     = trial - {1'b0, den_q};
	assign fits     = trial >= {1'b0, den_q};
	assign rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], fits};
			rem_q <= rem_next;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

>>> hdl/wrsi_smac.sv
// ----------------------------------------------------------------------------
// wrsi_smac
// Serial multiply-accumulate: a * b + c, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module wrsi_smac import wrsi_pkg::*; #(
	parameter int A_W = 48,
	parameter int B_W = 8,
	parameter int C_W = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [A_W-1:0]     a,
	input  logic [B_W-1:0]     b,
	input  logic [C_W-1:0]     c,
	output logic               done,
	output logic [A_W+B_W:0]   result
);

	localparam int RES_W = A_W + B_W + 1;
	localparam int CNT_W = $clog2(B_W + 1);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(B_W - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [RES_W-1:0] acc_q;
	logic [RES_W-1:0] a_q;
	logic [B_W-1:0]   b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= RES_W'(c);
			a_q   <= RES_W'(a);
			b_q   <= b;
		end else if (busy_q) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= {a_q[RES_W-2:0], 1'b0};
			b_q <= b_q >> 1;
		end
	end

	assign done   = done_q;
	assign result = acc_q;

endmodule

>>> hdl/wilder_rsi_stream_unit.sv
// ----------------------------------------------------------------------------
// wilder_rsi_stream_unit
// Streaming Wilder-smoothed RSI over Q16.16 prices, bit-serial datapath.
// ----------------------------------------------------------------------------
// Usage:
//   prices  : valid/ready sink, one price item (price, start_series) per item.
//   results : valid/ready source, one rsi item in Q7.FRAC_BITS percent.
//   cfg_we / cfg_wdata : window length, written while the unit is idle.
// The first price of a series (or any item with start_series set) is stored
// and gives no result; the next window-length changes are summed, and only
// the last of them gives a result; each later item gives one result.
// Steps of a result item: the serial multiply by W-1 (not for the first result
// of a series), the serial divide of both averages by W in two lanes, halving
// of both while their sum does not fit 32 bits (as after a window change), then
// the serial percentage divide unless the loss average is zero. prices.ready is
// low while an item is being worked; items that give no result do not stall.
// The finished result waits in an output register; a new price is accepted
// while it waits, and a second result holds in the done state until the
// receiver takes the first. Reset clears the series and sets the window to 14.
// ----------------------------------------------------------------------------
module wilder_rsi_stream_unit import wrsi_pkg::*; #(
	parameter int MAX_WINDOW = 255,
	parameter int FRAC_BITS  = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	wrsi_price_if.sink        prices,
	wrsi_rsi_if.source        results,
	input  logic              cfg_we,
	input  logic [WIN_W-1:0]  cfg_wdata
);

	localparam int RSI_W  = PCT_W + FRAC_BITS;
	localparam int GSC_W  = PRICE_W + PCT_W;
	localparam int NUMP_W = GSC_W + FRAC_BITS;
	localparam int SUM_W  = MEAN_W + 1;
	localparam logic [RSI_W-1:0] RSI_FULL = {PCT_SCALE, {FRAC_BITS{1'b0}}};
	localparam logic [WIN_W-1:0] W_CAP    = WIN_W'(MAX_WINDOW > 255 ? 255 : MAX_WINDOW);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_MUL  = 6'b000010,
		ST_DIVW = 6'b000100,
		ST_NORM = 6'b001000,
		ST_DIVP = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

	state_t              state_q;
	logic [WIN_W-1:0]    win_q;
	logic [SEEN_W-1:0]   seen_q;
	logic [PRICE_W-1:0]  last_q;
	logic [MEAN_W-1:0]   mg_q;
	logic [MEAN_W-1:0]   ml_q;
	logic [MEAN_W-1:0]   ng_q;
	logic [MEAN_W-1:0]   nl_q;
	logic [RSI_W-1:0]    res_q;
	logic                out_valid_q;
	logic [RSI_W-1:0]    out_rsi_q;

	logic [WIN_W-1:0]    win_eff;
	logic                accept;
	logic                fresh;
	logic                up;
	logic [PRICE_W-1:0]  gain;
	logic [PRICE_W-1:0]  loss;
	logic                warm;
	logic [SEEN_W-1:0]   seen_inc;
	logic                warm_end;
	logic [MEAN_W-1:0]   sum_g;
	logic [MEAN_W-1:0]   sum_l;
	logic                ld_first;
	logic                ld_warm;
	logic                ld_smooth;

	logic                mac_g_done;
	logic                mac_l_done;
	logic [MAC_W-1:0]    mac_g_res;
	logic [MAC_W-1:0]    mac_l_res;
	logic                mul_done;

	logic                divw_start;
	logic [MAC_W-1:0]    divw_num_g;
	logic [MAC_W-1:0]    divw_num_l;
	logic                div_g_done;
	logic                div_l_done;
	logic [MAC_W-1:0]    div_g_quo;
	logic [MAC_W-1:0]    div_l_quo;
	logic                divw_done;

	logic [SUM_W-1:0]    nsum;
	logic                too_big;
	logic                l_zero;
	logic                pct_start;
	logic [GSC_W-1:0]    g_scaled;
	logic [NUMP_W-1:0]   pct_num;
	logic                pct_done;
	logic [NUMP_W-1:0]   pct_quo;
	logic                emit;

	// window of 0 acts as 1, above the cap acts as the cap
	always_comb begin
		if (win_q == '0) begin
			win_eff = WIN_W'(1);
		end else if (win_q > W_CAP) begin
			win_eff = W_CAP;
		end else begin
			win_eff = win_q;
		end
	end

	assign prices.ready = (state_q == ST_IDLE);
	assign accept       = prices.valid && prices.ready;
	assign fresh        = prices.start_series || (seen_q == '0);

	assign up   = prices.price > last_q;
	assign gain = up ? prices.price - last_q : '0;
	assign loss = up ? '0 : last_q - prices.price;

	assign warm     = seen_q <= {1'b0, win_eff};
	assign seen_inc = seen_q + 1'b1;
	assign warm_end = seen_inc > {1'b0, win_eff};
	assign sum_g    = mg_q + MEAN_W'(gain);
	assign sum_l    = ml_q + MEAN_W'(loss);

	assign ld_first  = accept && fresh;
	assign ld_warm   = accept && !fresh && warm;
	assign ld_smooth = accept && !fresh && !warm;

	wrsi_smac #(.A_W(MEAN_W), .B_W(WIN_W), .C_W(PRICE_W)) u_mac_g (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ld_smooth),
		.a      (mg_q),
		.b      (win_eff - 1'b1),
		.c      (gain),
		.done   (mac_g_done),
		.result (mac_g_res)
	);

	wrsi_smac #(.A_W(MEAN_W), .B_W(WIN_W), .C_W(PRICE_W)) u_mac_l (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ld_smooth),
		.a      (ml_q),
		.b      (win_eff - 1'b1),
		.c      (loss),
		.done   (mac_l_done),
		.result (mac_l_res)
	);

	assign mul_done   = (state_q == ST_MUL) && mac_g_done && mac_l_done;
	assign divw_start = (ld_warm && warm_end) || mul_done;
	assign divw_num_g = (state_q == ST_MUL) ? mac_g_res : MAC_W'(sum_g);
	assign divw_num_l = (state_q == ST_MUL) ? mac_l_res : MAC_W'(sum_l);

	wrsi_sdiv #(.NUM_W(MAC_W), .DEN_W(WIN_W)) u_div_g (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (divw_start),
		.dividend (divw_num_g),
		.divisor  (win_eff),
		.done     (div_g_done),
		.quotient (div_g_quo)
	);

	wrsi_sdiv #(.NUM_W(MAC_W), .DEN_W(WIN_W)) u_div_l (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (divw_start),
		.dividend (divw_num_l),
		.divisor  (win_eff),
		.done     (div_l_done),
		.quotient (div_l_quo)
	);

	assign divw_done = (state_q == ST_DIVW) && div_g_done && div_l_done;

	// halve both while g + l does not fit 32 bits
	assign nsum      = {1'b0, ng_q} + {1'b0, nl_q};
	assign too_big   = |nsum[SUM_W-1:PRICE_W];
	assign l_zero    = (nl_q == '0);
	assign pct_start = (state_q == ST_NORM) && !l_zero && !too_big;
	assign g_scaled  = GSC_W'(ng_q[PRICE_W-1:0]) * GSC_W'(PCT_SCALE);
	assign pct_num   = {g_scaled, {FRAC_BITS{1'b0}}};

	wrsi_sdiv #(.NUM_W(NUMP_W), .DEN_W(PRICE_W)) u_div_pct (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (pct_start),
		.dividend (pct_num),
		.divisor  (nsum[PRICE_W-1:0]),
		.done     (pct_done),
		.quotient (pct_quo)
	);

	assign emit = (state_q == ST_DONE) && (!out_valid_q || results.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			win_q       <= WIN_RESET;
			seen_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				win_q <= cfg_wdata;
			end
			if (ld_first) begin
				seen_q <= SEEN_W'(1);
			end else if (ld_warm) begin
				seen_q <= seen_inc;
			end else if (ld_smooth) begin
				seen_q <= {1'b0, win_eff} + 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (ld_warm && warm_end) begin
						state_q <= ST_DIVW;
					end else if (ld_smooth) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (mul_done) begin
						state_q <= ST_DIVW;
					end
				end
				ST_DIVW: begin
					if (divw_done) begin
						state_q <= ST_NORM;
					end
				end
				ST_NORM: begin
					if (l_zero) begin
						state_q <= ST_DONE;
					end else if (!too_big) begin
						state_q <= ST_DIVP;
					end
				end
				ST_DIVP: begin
					if (pct_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (emit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_q <= prices.price;
		end
		if (ld_first) begin
			mg_q <= '0;
			ml_q <= '0;
		end else if (ld_warm) begin
			mg_q <= sum_g;
			ml_q <= sum_l;
		end else if (divw_done) begin
			mg_q <= div_g_quo[MEAN_W-1:0];
			ml_q <= div_l_quo[MEAN_W-1:0];
		end
		if (divw_done) begin
			ng_q <= div_g_quo[MEAN_W-1:0];
			nl_q <= div_l_quo[MEAN_W-1:0];
		end else if ((state_q == ST_NORM) && !l_zero && too_big) begin
			ng_q <= ng_q >> 1;
			nl_q <= nl_q >> 1;
		end
		if ((state_q == ST_NORM) && l_zero) begin
			res_q <= RSI_FULL;
		end else if ((state_q == ST_DIVP) && pct_done) begin
			res_q <= pct_quo[RSI_W-1:0];
		end
		if (emit) begin
			out_rsi_q <= res_q;
		end
	end

	assign results.valid = out_valid_q;
	assign results.rsi   = out_rsi_q;

endmodule

>>> hdl/wrsi_checker.sv
// ----------------------------------------------------------------------------
// wrsi_checker
// Port-level checks on the RSI unit, bound to the top level.
// ----------------------------------------------------------------------------
module wrsi_checker import wrsi_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [PCT_W+FRAC_BITS-1:0] out_rsi
);

	localparam int RSI_W = PCT_W + FRAC_BITS;
	localparam logic [RSI_W-1:0] RSI_FULL = {PCT_SCALE, {FRAC_BITS{1'b0}}};

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_rsi))
		else $error("result changed while stalled");

	// percent never exceeds one hundred
	a_rsi_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_rsi <= RSI_FULL)
		else $error("rsi above 100 percent");

	// the serial path never delivers a new result the cycle after an accept
	a_no_fast_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared too soon after an item");

	// nothing is offered during reset
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result valid during reset");

endmodule

bind wilder_rsi_stream_unit wrsi_checker #(.FRAC_BITS(FRAC_BITS)) u_wrsi_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (prices.valid),
	.in_ready  (prices.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_rsi   (results.rsi)
);

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Wilder RSI stream unit: directed corner prices
// and window changes, then random price walks under several window lengths
// and flow-control patterns, every RSI item checked against a local model.
// ----------------------------------------------------------------------------
module tb import wrsi_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC_BITS   = 16;
	localparam int MAX_WIN     = 255;
	localparam int RSI_W       = PCT_W + FRAC_BITS;
	localparam int SETTLE      = 200;   // longer than one result plus halvings
	localparam int HOLD_CYCLES = 400;
	localparam int QUIET_LIMIT = 4000;
	localparam int N_PHASES    = 7;

	localparam logic [WIN_W-1:0] PHASE_WIN[N_PHASES] = '{8'd1, 8'd0, 8'd2, 8'd14, 8'd5,
		8'd255, 8'd0};
	localparam int PHASE_ITEMS[N_PHASES] = '{40, 35, 40, 45, 40, 270, 40};

	class rsi_scoreboard;
		logic [WIN_W-1:0]   window_reg;
		logic [PRICE_W-1:0] prev_price;
		int unsigned        seen;
		bit [63:0]          acc_gain;
		bit [63:0]          acc_loss;
		logic [RSI_W-1:0]   rsi_due[$];
		int                 errors;

		function new();
			window_reg = WIN_RESET;
			prev_price = '0;
			seen       = 0;
			acc_gain   = '0;
			acc_loss   = '0;
			errors     = 0;
		endfunction

		function void set_window(logic [WIN_W-1:0] v);
			window_reg = v;
		endfunction

		function int pending();
			return rsi_due.size();
		endfunction

		function logic [RSI_W-1:0] pct_of(bit [63:0] g, bit [63:0] l);
			bit [63:0] num;
			if (l == 0)
				return RSI_W'(64'(PCT_SCALE) << FRAC_BITS);
			// averages blown up by a window change are scaled down first
			while (g + l >= 64'h1_0000_0000) begin
				g = g >> 1;
				l = l >> 1;
			end
			if (l == 0)
				return RSI_W'(64'(PCT_SCALE) << FRAC_BITS);
			num = (g * 64'(PCT_SCALE)) << FRAC_BITS;
			return RSI_W'(num / (g + l));
		endfunction

		function void take_price(logic [PRICE_W-1:0] p, logic s);
			bit [63:0] w;
			bit [63:0] gain;
			bit [63:0] loss;
			w = (window_reg == 0) ? 64'd1 : 64'(window_reg);
			if (w > 64'(MAX_WIN))
				w = 64'(MAX_WIN);
			gain = 0;
			loss = 0;
			if (s || seen == 0) begin
				prev_price = p;
				seen       = 1;
				acc_gain   = 0;
				acc_loss   = 0;
				return;
			end
			if (p > prev_price)
				gain = 64'(p - prev_price);
			else
				loss = 64'(prev_price - p);
			prev_price = p;
			if (seen <= w) begin
				acc_gain = (acc_gain + gain) & 64'hFFFF_FFFF_FFFF;
				acc_loss = (acc_loss + loss) & 64'hFFFF_FFFF_FFFF;
				seen++;
				if (seen <= w)
					return;
				acc_gain = acc_gain / w;
				acc_loss = acc_loss / w;
			end else begin
				acc_gain = ((acc_gain * (w - 1) + gain) / w) & 64'hFFFF_FFFF_FFFF;
				acc_loss = ((acc_loss * (w - 1) + loss) / w) & 64'hFFFF_FFFF_FFFF;
				seen     = int'(w) + 1;
			end
			rsi_due.insert(rsi_due.size(), pct_of(acc_gain, acc_loss));
		endfunction

		function void check_rsi(logic [RSI_W-1:0] got);
			logic [RSI_W-1:0] want;
			if (rsi_due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected rsi item: %0d", got);
				return;
			end
			want = rsi_due.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10)
					$display("rsi mismatch: expected %0d, got %0d", want, got);
			end
		endfunction

		function void drain_check();
			if (rsi_due.size() != 0) begin
				errors++;
				if (errors <= 10)
					$display("%0d rsi items never arrived", rsi_due.size());
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [WIN_W-1:0] cfg_wdata;

	wrsi_price_if px();
	wrsi_rsi_if #(.RSI_W(RSI_W)) rx();

	wilder_rsi_stream_unit #(
		.MAX_WINDOW (MAX_WIN),
		.FRAC_BITS  (FRAC_BITS)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.prices     (px),
		.results    (rx),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata)
	);

	rsi_scoreboard sb = new();

	int send_gap_pct   = 0;
	int recv_stall_pct = 0;
	bit hold_req = 1'b0;
	bit hold_ack = 1'b0;
	int quiet    = 0;
	logic [PRICE_W-1:0] cur_price;

	always #5 clk = ~clk;

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		rx.ready  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req != hold_ack) begin
				hold_ack  = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rx.ready = 1'b0;
			end else begin
				rx.ready = ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && rx.valid === 1'b1 && rx.ready === 1'b1)
			sb.check_rsi(rx.rsi);
	end

	always @(posedge clk) begin
		if (arst_n !== 1'b1 || (px.valid && px.ready) || (rx.valid && rx.ready)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	task automatic cfg_write(input logic [WIN_W-1:0] v);
		cfg_we    = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we    = 1'b0;
		cfg_wdata = WIN_W'($urandom);
		sb.set_window(v);
	endtask

	task automatic send_price(input logic [PRICE_W-1:0] p, input logic s);
		while ($urandom_range(99) < send_gap_pct) begin
			px.valid        = 1'b0;
			px.price        = $urandom;
			px.start_series = 1'($urandom_range(1));
			@(negedge clk);
		end
		px.valid        = 1'b1;
		px.price        = p;
		px.start_series = s;
		@(posedge clk);
		while (!px.ready)
			@(posedge clk);
		sb.take_price(p, s);
		cur_price = p;
		@(negedge clk);
	endtask

	// let every outstanding item drain, then give the unit time to finish
	task automatic settle();
		px.valid = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	function automatic logic [PRICE_W-1:0] next_price(logic [PRICE_W-1:0] prev);
		int unsigned pick;
		logic [PRICE_W-1:0] d;
		pick = $urandom_range(99);
		if (pick < 45)
			d = $urandom_range(32'h0000_FFFF);
		else if (pick < 70)
			d = $urandom_range(32'h00FF_FFFF);
		else if (pick < 82)
			return prev;
		else if (pick < 92)
			return $urandom;
		else
			return $urandom_range(1) ? '1 : '0;
		if ($urandom_range(1))
			return (prev > ~d) ? '1 : prev + d;
		return (prev < d) ? '0 : prev - d;
	endfunction

	initial begin
		logic [WIN_W-1:0] win;
		logic             st;
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_wdata       = '0;
		px.valid        = 1'b0;
		px.price        = '0;
		px.start_series = 1'b0;
		cur_price       = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// short window: first price without flag, flat, full gain, full loss, restart
		cfg_write(8'd2);
		send_price(32'h0000_0000, 1'b0);
		send_price(32'h0000_0000, 1'b0);
		send_price(32'hFFFF_FFFF, 1'b0);
		send_price(32'h0000_0000, 1'b0);
		send_price(32'h0000_0000, 1'b0);
		send_price(32'hFFFF_FFFF, 1'b0);
		send_price(32'h1234_5678, 1'b1);
		send_price(32'h1234_5677, 1'b0);
		send_price(32'h1234_5677, 1'b0);
		send_price(32'h8000_0001, 1'b0);
		settle();

		// big sums under the widest window, then shrink it mid warm-up so the
		// sums are taken as averages and overflow 32 bits
		cfg_write(8'd255);
		send_price(32'h0000_0000, 1'b1);
		for (int i = 0; i < 8; i++)
			send_price(i[0] ? 32'h0000_0000 : 32'hFFFF_FFFF, 1'b0);
		settle();
		cfg_write(8'd2);
		send_price(32'hFFFF_FFFF, 1'b0);
		send_price(32'h0000_0000, 1'b0);
		send_price(32'h7FFF_FFFF, 1'b0);
		settle();
		cfg_write(8'd0);
		send_price(32'h0000_0001, 1'b0);
		send_price(32'hFFFF_FFFE, 1'b0);
		settle();

		for (int ph = 0; ph < N_PHASES; ph++) begin
			case (ph % 4)
				0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_gap_pct = 65; recv_stall_pct = 0;  end
				2: begin send_gap_pct = 0;  recv_stall_pct = 65; end
				default: begin send_gap_pct = 35; recv_stall_pct = 35; end
			endcase
			win = (ph == N_PHASES - 1) ? WIN_W'($urandom_range(3, 40)) : PHASE_WIN[ph];
			cfg_write(win);
			if (ph == 0)
				hold_req = ~hold_req;
			for (int i = 0; i < PHASE_ITEMS[ph]; i++) begin
				// the widest window needs one unbroken series to reach results
				if (i == 0)
					st = (win == 8'd255) ? 1'b1 : 1'($urandom_range(1));
				else
					st = (win != 8'd255) && ($urandom_range(99) < 4);
				send_price(next_price(cur_price), st);
			end
			settle();
		end

		sb.drain_check();
		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
